### hdl/wbit_pkg.sv
// ============================================================================
// wbit_pkg
// Shared codes, widths, reset values and control types of the work/break
// interval timer.
// ============================================================================
package wbit_pkg;

  // Field widths
  localparam int REQ_W   = 2;
  localparam int TIME_W  = 32;
  localparam int MV_W    = 16;
  localparam int VAL_W   = 16;
  localparam int SCALE_W = 8;
  localparam int BEEP_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SHORT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LONG  = 2'd2;

  // Beep pattern codes
  localparam logic [BEEP_W-1:0] BEEP_NONE   = 3'd0;
  localparam logic [BEEP_W-1:0] BEEP_SHORT  = 3'd1;
  localparam logic [BEEP_W-1:0] BEEP_MEDIUM = 3'd2;
  localparam logic [BEEP_W-1:0] BEEP_MML    = 3'd3;
  localparam logic [BEEP_W-1:0] BEEP_LONG   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORK_SECONDS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_SECONDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_MIN_MV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_MAX_MV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_FULL      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_SHOW_MS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_FULL      = 3'd7;

  // Configuration reset values
  localparam logic [VAL_W-1:0]   RST_WORK_SECONDS  = 16'd1500;
  localparam logic [VAL_W-1:0]   RST_BREAK_SECONDS = 16'd300;
  localparam logic [SCALE_W-1:0] RST_BREAK_SCALE   = 8'd5;
  localparam logic [VAL_W-1:0]   RST_BATT_MIN_MV   = 16'd3000;
  localparam logic [VAL_W-1:0]   RST_BATT_MAX_MV   = 16'd4200;
  localparam logic [VAL_W-1:0]   RST_BAR_FULL      = 16'd1500;
  localparam logic [VAL_W-1:0]   RST_BATT_SHOW_MS  = 16'd3000;
  localparam logic [VAL_W-1:0]   RST_PWM_FULL      = 16'd4095;

  // Battery charge divider: one quotient bit per cycle
  localparam int DIVIDEND_W = 2 * VAL_W;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input beat
    logic exec;      // apply the item to the timer state
    logic div_step;  // advance the divider by one bit
    logic load_out;  // move the result into the output register
  } wbit_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;  // the latched item needs the charge division
    logic div_last;  // the divider is on its final bit
  } wbit_stat_t;

endpackage

### hdl/wbit_ctrl.sv
// ============================================================================
// wbit_ctrl
// Sequencer of the interval timer: takes an input beat, runs the execute
// step and the optional division, and hands the result to the output register.
// ============================================================================
module wbit_ctrl
  import wbit_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  wbit_stat_t stat,
  output wbit_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Sequence one item at a time
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the output beat until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/wbit_dp.sv
// ============================================================================
// wbit_dp
// Datapath of the interval timer: configuration registers, timer state,
// result computation, serial charge divider and the output register.
// ============================================================================
module wbit_dp
  import wbit_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input payload
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic [MV_W-1:0]       in_battery_mv,
  // control
  input  wbit_cmd_t             cmd,
  output wbit_stat_t            stat,
  // output payload
  output logic                  out_bar_write,
  output logic [VAL_W-1:0]      out_bar_value,
  output logic                  out_leds_write,
  output logic [VAL_W-1:0]      out_red_pwm,
  output logic [VAL_W-1:0]      out_green_pwm,
  output logic [BEEP_W-1:0]     out_beep_pattern,
  output logic                  out_is_running,
  output logic                  out_in_break,
  output logic [VAL_W-1:0]      out_seconds_left
);

  // Configuration registers
  logic [VAL_W-1:0]   work_sec_r, break_sec_r, batt_min_r, batt_max_r;
  logic [VAL_W-1:0]   bar_full_r, batt_show_r, pwm_full_r;
  logic [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_sec_r  <= RST_WORK_SECONDS;
      break_sec_r <= RST_BREAK_SECONDS;
      scale_r     <= RST_BREAK_SCALE;
      batt_min_r  <= RST_BATT_MIN_MV;
      batt_max_r  <= RST_BATT_MAX_MV;
      bar_full_r  <= RST_BAR_FULL;
      batt_show_r <= RST_BATT_SHOW_MS;
      pwm_full_r  <= RST_PWM_FULL;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WORK_SECONDS:  work_sec_r  <= cfg_wdata;
        CFG_BREAK_SECONDS: break_sec_r <= cfg_wdata;
        CFG_BREAK_SCALE:   scale_r     <= cfg_wdata[SCALE_W-1:0];
        CFG_BATT_MIN_MV:   batt_min_r  <= cfg_wdata;
        CFG_BATT_MAX_MV:   batt_max_r  <= cfg_wdata;
        CFG_BAR_FULL:      bar_full_r  <= cfg_wdata;
        CFG_BATT_SHOW_MS:  batt_show_r <= cfg_wdata;
        CFG_PWM_FULL:      pwm_full_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latched input beat
  logic [REQ_W-1:0]  req_r;
  logic [TIME_W-1:0] now_r;
  logic [MV_W-1:0]   mv_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      now_r <= in_now_ms;
      mv_r  <= in_battery_mv;
    end
  end

  // Timer state
  logic [VAL_W-1:0]  sec_r, sec_nxt;
  logic              run_r, run_nxt;
  logic              brk_r, brk_nxt;
  logic              blink_r, blink_nxt;
  logic [TIME_W-1:0] deadline_r, deadline_nxt;

  // Result stage
  logic              res_bar_w_r, res_bar_w_nxt;
  logic [VAL_W-1:0]  res_bar_v_r, res_bar_v_nxt;
  logic              res_div_r, res_div_nxt;
  logic              res_led_w_r, res_led_w_nxt;
  logic [VAL_W-1:0]  res_red_r, res_red_nxt;
  logic [VAL_W-1:0]  res_green_r, res_green_nxt;
  logic [BEEP_W-1:0] res_beep_r, res_beep_nxt;

  // Divider
  logic [DIVIDEND_W-1:0] dvd_r, dvd_nxt;
  logic [VAL_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VAL_W-1:0]      span;
  logic [VAL_W:0]        part, trial;

  // Progress and charge helpers
  logic [VAL_W+SCALE_W-1:0] prog_wide;
  logic [VAL_W-1:0]         prog;
  logic [VAL_W-1:0]         sec_dec;
  logic                     mv_above, mv_below;
  logic [DIVIDEND_W-1:0]    charge_prod;

  assign span        = batt_max_r - batt_min_r;
  assign mv_above    = (mv_r > batt_max_r);
  assign mv_below    = (mv_r < batt_min_r);
  assign charge_prod = DIVIDEND_W'(mv_r - batt_min_r) * DIVIDEND_W'(bar_full_r);
  assign prog_wide   = (VAL_W+SCALE_W)'(sec_r) * (VAL_W+SCALE_W)'(scale_r);
  assign sec_dec     = (sec_r == '0) ? '0 : sec_r - VAL_W'(1);

  always_comb begin
    if (!brk_r) begin
      prog = sec_r;
    end else if (prog_wide > (VAL_W+SCALE_W)'({VAL_W{1'b1}})) begin
      prog = {VAL_W{1'b1}};
    end else begin
      prog = prog_wide[VAL_W-1:0];
    end
  end

  // Only a long press with an in-range reading and distinct limits needs the division
  assign stat.need_div = (req_r == REQ_LONG) && !mv_above && !mv_below &&
                         (batt_max_r != batt_min_r);
  assign stat.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // Apply the item to the timer state
  always_comb begin
    sec_nxt       = sec_r;
    run_nxt       = run_r;
    brk_nxt       = brk_r;
    blink_nxt     = blink_r;
    deadline_nxt  = deadline_r;
    res_bar_w_nxt = res_bar_w_r;
    res_bar_v_nxt = res_bar_v_r;
    res_div_nxt   = res_div_r;
    res_led_w_nxt = res_led_w_r;
    res_red_nxt   = res_red_r;
    res_green_nxt = res_green_r;
    res_beep_nxt  = res_beep_r;
    if (cmd.exec) begin
      res_bar_w_nxt = 1'b0;
      res_bar_v_nxt = '0;
      res_div_nxt   = 1'b0;
      res_led_w_nxt = 1'b0;
      res_red_nxt   = '0;
      res_green_nxt = '0;
      res_beep_nxt  = BEEP_NONE;
      case (req_r)
        REQ_TICK: begin
          if (now_r > deadline_r) begin
            res_bar_w_nxt = 1'b1;
            res_bar_v_nxt = prog;
          end
          if (!run_r) begin
            // blink the LED of the current mode
            res_led_w_nxt = 1'b1;
            if (brk_r) begin
              res_green_nxt = blink_r ? pwm_full_r : '0;
            end else begin
              res_red_nxt = blink_r ? pwm_full_r : '0;
            end
            blink_nxt = !blink_r;
          end else begin
            sec_nxt = sec_dec;
            if (sec_dec == '0) begin
              // switch mode and reload
              res_led_w_nxt = 1'b1;
              if (!brk_r) begin
                res_beep_nxt  = BEEP_MML;
                res_green_nxt = pwm_full_r;
                sec_nxt       = break_sec_r;
                brk_nxt       = 1'b1;
              end else begin
                res_beep_nxt = BEEP_LONG;
                res_red_nxt  = pwm_full_r;
                sec_nxt      = work_sec_r;
                brk_nxt      = 1'b0;
              end
            end
          end
        end
        REQ_SHORT: begin
          res_beep_nxt  = BEEP_SHORT;
          res_led_w_nxt = 1'b1;
          run_nxt       = !run_r;
          if (!run_r) begin
            if (brk_r) begin
              res_green_nxt = pwm_full_r;
            end else begin
              res_red_nxt = pwm_full_r;
            end
          end
        end
        REQ_LONG: begin
          res_beep_nxt  = BEEP_MEDIUM;
          run_nxt       = 1'b0;
          brk_nxt       = 1'b0;
          sec_nxt       = work_sec_r;
          res_led_w_nxt = 1'b1;
          res_red_nxt   = pwm_full_r;
          res_bar_w_nxt = 1'b1;
          deadline_nxt  = now_r + TIME_W'(batt_show_r);
          if (mv_above) begin
            res_bar_v_nxt = bar_full_r;
          end else if (mv_below) begin
            res_bar_v_nxt = '0;
          end else if (batt_max_r == batt_min_r) begin
            res_bar_v_nxt = bar_full_r;
          end else begin
            res_div_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Restoring division, one quotient bit per step
  assign part  = {rem_r, dvd_r[DIVIDEND_W-1]};
  assign trial = part - {1'b0, span};

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (cmd.exec) begin
      dvd_nxt = charge_prod;
      rem_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.div_step) begin
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (!trial[VAL_W]) begin
        rem_nxt = trial[VAL_W-1:0];
        dvd_nxt = {dvd_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = part[VAL_W-1:0];
        dvd_nxt = {dvd_r[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r      <= RST_WORK_SECONDS;
      run_r      <= 1'b0;
      brk_r      <= 1'b0;
      blink_r    <= 1'b0;
      deadline_r <= '0;
      cnt_r      <= '0;
    end else begin
      sec_r      <= sec_nxt;
      run_r      <= run_nxt;
      brk_r      <= brk_nxt;
      blink_r    <= blink_nxt;
      deadline_r <= deadline_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_bar_w_r <= res_bar_w_nxt;
    res_bar_v_r <= res_bar_v_nxt;
    res_div_r   <= res_div_nxt;
    res_led_w_r <= res_led_w_nxt;
    res_red_r   <= res_red_nxt;
    res_green_r <= res_green_nxt;
    res_beep_r  <= res_beep_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
  end

  // Output register: load the finished result
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_bar_write    <= res_bar_w_r;
      out_bar_value    <= res_div_r ? dvd_r[VAL_W-1:0] : res_bar_v_r;
      out_leds_write   <= res_led_w_r;
      out_red_pwm      <= res_red_r;
      out_green_pwm    <= res_green_r;
      out_beep_pattern <= res_beep_r;
      out_is_running   <= run_r;
      out_in_break     <= brk_r;
      out_seconds_left <= sec_r;
    end
  end

endmodule

### hdl/work_break_interval_timer_unit.sv
// ============================================================================
// work_break_interval_timer_unit
// Work/break countdown controller driven by tick and button events.
// ============================================================================
// Each accepted event yields exactly one result beat. Ticks and short presses
// go through the execute state to the done state, which loads the output
// register; a long press with the battery reading inside the configured
// window, limits included, and distinct limits also runs the 32-step restoring
// divider that scales the charge. Events are processed one at a time; a new
// event is accepted as soon as the previous one sits in the output register,
// even while that beat still waits for out_ready. Configuration writes take
// effect on the next clock and are meant for idle periods only.
module work_break_interval_timer_unit
  import wbit_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // event channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic [MV_W-1:0]       in_battery_mv,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_bar_write,
  output logic [VAL_W-1:0]      out_bar_value,
  output logic                  out_leds_write,
  output logic [VAL_W-1:0]      out_red_pwm,
  output logic [VAL_W-1:0]      out_green_pwm,
  output logic [BEEP_W-1:0]     out_beep_pattern,
  output logic                  out_is_running,
  output logic                  out_in_break,
  output logic [VAL_W-1:0]      out_seconds_left
);

  wbit_cmd_t  cmd;
  wbit_stat_t stat;

  // Sequencer
  wbit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath
  wbit_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_req_type),
    .in_now_ms        (in_now_ms),
    .in_battery_mv    (in_battery_mv),
    .cmd              (cmd),
    .stat             (stat),
    .out_bar_write    (out_bar_write),
    .out_bar_value    (out_bar_value),
    .out_leds_write   (out_leds_write),
    .out_red_pwm      (out_red_pwm),
    .out_green_pwm    (out_green_pwm),
    .out_beep_pattern (out_beep_pattern),
    .out_is_running   (out_is_running),
    .out_in_break     (out_in_break),
    .out_seconds_left (out_seconds_left)
  );

endmodule

### hdl/wbit_checker.sv
// ============================================================================
// wbit_checker
// Port-level checks of the interval timer result channel, bound to the top.
// ============================================================================
module wbit_checker
  import wbit_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_bar_write,
  input logic [VAL_W-1:0]  out_bar_value,
  input logic              out_leds_write,
  input logic [VAL_W-1:0]  out_red_pwm,
  input logic [VAL_W-1:0]  out_green_pwm,
  input logic [BEEP_W-1:0] out_beep_pattern,
  input logic              out_is_running,
  input logic              out_in_break
);

  // A stalled result beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bar_value) &&
      $stable(out_beep_pattern))
    else $error("result beat changed while stalled");

  // No bar write means a zero bar value
  a_bar_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bar_write |-> out_bar_value == '0)
    else $error("bar value without bar write");

  // Green stays dark without an LED write and whenever red is lit
  a_led_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_leds_write || out_red_pwm != '0) |-> out_green_pwm == '0)
    else $error("unexpected green PWM value");

  // A long press leaves the block paused in work mode with a bar write
  a_long_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beep_pattern == BEEP_MEDIUM |->
      !out_is_running && !out_in_break && out_bar_write)
    else $error("long press result inconsistent");

  // A switch into break mode happens only while running
  a_to_break: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beep_pattern == BEEP_MML |-> out_is_running && out_in_break)
    else $error("work-to-break switch inconsistent");

endmodule

bind work_break_interval_timer_unit wbit_checker u_wbit_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_bar_write    (out_bar_write),
  .out_bar_value    (out_bar_value),
  .out_leds_write   (out_leds_write),
  .out_red_pwm      (out_red_pwm),
  .out_green_pwm    (out_green_pwm),
  .out_beep_pattern (out_beep_pattern),
  .out_is_running   (out_is_running),
  .out_in_break     (out_in_break)
);

### bench/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the work/break interval timer. Sends tick, short
// press, long press and unknown events under random idling on both channels,
// predicts every result beat, and compares each beat field by field.
// ============================================================================
module testbench;
  import wbit_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_PRINTED     = 100;

  typedef struct packed {
    logic [VAL_W-1:0]   work_s;
    logic [VAL_W-1:0]   break_s;
    logic [SCALE_W-1:0] scale;
    logic [VAL_W-1:0]   batt_min;
    logic [VAL_W-1:0]   batt_max;
    logic [VAL_W-1:0]   bar_full;
    logic [VAL_W-1:0]   show_ms;
    logic [VAL_W-1:0]   pwm_full;
  } timer_settings_t;

  typedef struct packed {
    logic              bar_write;
    logic [VAL_W-1:0]  bar_value;
    logic              leds_write;
    logic [VAL_W-1:0]  red_pwm;
    logic [VAL_W-1:0]  green_pwm;
    logic [BEEP_W-1:0] beep;
    logic              running;
    logic              in_break;
    logic [VAL_W-1:0]  seconds_left;
  } timer_result_t;

  localparam timer_settings_t DEFAULT_SETTINGS = '{
    RST_WORK_SECONDS, RST_BREAK_SECONDS, RST_BREAK_SCALE, RST_BATT_MIN_MV,
    RST_BATT_MAX_MV, RST_BAR_FULL, RST_BATT_SHOW_MS, RST_PWM_FULL};
  localparam timer_settings_t LOW_SETTINGS  = '{
    16'd1, 16'd1, 8'd1, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0};
  localparam timer_settings_t HIGH_SETTINGS = '{
    16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};

  // Clock, reset and block ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [REQ_W-1:0]      in_req_type = '0;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic [MV_W-1:0]       in_battery_mv = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_bar_write;
  logic [VAL_W-1:0]      out_bar_value;
  logic                  out_leds_write;
  logic [VAL_W-1:0]      out_red_pwm;
  logic [VAL_W-1:0]      out_green_pwm;
  logic [BEEP_W-1:0]     out_beep_pattern;
  logic                  out_is_running;
  logic                  out_in_break;
  logic [VAL_W-1:0]      out_seconds_left;

  // Predicted timer state and the register copy it runs on
  timer_settings_t  tmr_cfg      = DEFAULT_SETTINGS;
  logic [VAL_W-1:0] tmr_seconds  = RST_WORK_SECONDS;
  logic             tmr_running  = 1'b0;
  logic             tmr_break    = 1'b0;
  logic             tmr_blink    = 1'b0;
  logic [TIME_W-1:0] tmr_deadline = '0;

  timer_result_t pending_responses[$];
  int unsigned   fail_count = 0;
  int unsigned   quiet_cycles = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  bit            idling_on = 1'b1;
  bit            hold_off_request = 1'b0;

  always #4 clk = ~clk;

  work_break_interval_timer_unit DUT (.*);

  // Scale a battery reading into the configured bar range
  function automatic logic [VAL_W-1:0] battery_charge_of(logic [MV_W-1:0] mv);
    logic [31:0] span;
    logic [31:0] num;
    if (mv > tmr_cfg.batt_max) return tmr_cfg.bar_full;
    if (mv < tmr_cfg.batt_min) return '0;
    if (tmr_cfg.batt_max == tmr_cfg.batt_min) return tmr_cfg.bar_full;
    span = {16'd0, tmr_cfg.batt_max} - {16'd0, tmr_cfg.batt_min};
    num  = ({16'd0, mv} - {16'd0, tmr_cfg.batt_min}) * {16'd0, tmr_cfg.bar_full};
    return 16'(num / span);
  endfunction

  // Apply one event to the predicted state and return the beat it yields
  function automatic timer_result_t compute_timer_response(logic [REQ_W-1:0] req,
                                                          logic [TIME_W-1:0] now,
                                                          logic [MV_W-1:0] mv);
    timer_result_t r;
    logic [31:0]   progress;
    r = '0;
    case (req)
      REQ_TICK: begin
        progress = {16'd0, tmr_seconds};
        if (tmr_break) begin
          progress = progress * {24'd0, tmr_cfg.scale};
          if (progress > 32'd65535) progress = 32'd65535;
        end
        if (now > tmr_deadline) begin
          r.bar_write = 1'b1;
          r.bar_value = progress[15:0];
        end
        if (!tmr_running) begin
          // paused: blink the LED of the current mode
          r.leds_write = 1'b1;
          if (tmr_break) r.green_pwm = tmr_blink ? tmr_cfg.pwm_full : '0;
          else r.red_pwm = tmr_blink ? tmr_cfg.pwm_full : '0;
          tmr_blink = ~tmr_blink;
        end else begin
          // running: count down, switch mode at zero without wrapping
          if (tmr_seconds != 0) tmr_seconds = tmr_seconds - 16'd1;
          if (tmr_seconds == 0) begin
            r.leds_write = 1'b1;
            if (!tmr_break) begin
              r.beep      = BEEP_MML;
              r.green_pwm = tmr_cfg.pwm_full;
              tmr_seconds = tmr_cfg.break_s;
              tmr_break   = 1'b1;
            end else begin
              r.beep      = BEEP_LONG;
              r.red_pwm   = tmr_cfg.pwm_full;
              tmr_seconds = tmr_cfg.work_s;
              tmr_break   = 1'b0;
            end
          end
        end
      end
      REQ_SHORT: begin
        r.beep       = BEEP_SHORT;
        r.leds_write = 1'b1;
        if (!tmr_running) begin
          tmr_running = 1'b1;
          if (tmr_break) r.green_pwm = tmr_cfg.pwm_full;
          else r.red_pwm = tmr_cfg.pwm_full;
        end else begin
          tmr_running = 1'b0;
        end
      end
      REQ_LONG: begin
        r.beep       = BEEP_MEDIUM;
        tmr_running  = 1'b0;
        tmr_break    = 1'b0;
        r.bar_write  = 1'b1;
        r.bar_value  = battery_charge_of(mv);
        tmr_deadline = now + {16'd0, tmr_cfg.show_ms};
        r.leds_write = 1'b1;
        r.red_pwm    = tmr_cfg.pwm_full;
        tmr_seconds  = tmr_cfg.work_s;
      end
      default: begin
        // unknown request: no writes, no beep, state kept
      end
    endcase
    r.running      = tmr_running;
    r.in_break     = tmr_break;
    r.seconds_left = tmr_seconds;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Offer one event beat, hold it until accepted, then predict its result
  task automatic send_event(logic [REQ_W-1:0] req, logic [TIME_W-1:0] now,
                            logic [MV_W-1:0] mv);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_now_ms     <= now;
    in_battery_mv <= mv;
    do @(posedge clk); while (!in_ready);
    pending_responses.push_back(compute_timer_response(req, now, mv));
  endtask

  // Drop valid, wait for every pending beat, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers back to back
  task automatic load_settings(timer_settings_t s);
    logic [CFG_DATA_W-1:0] vals[8];
    vals[CFG_WORK_SECONDS]  = s.work_s;
    vals[CFG_BREAK_SECONDS] = s.break_s;
    vals[CFG_BREAK_SCALE]   = {8'd0, s.scale};
    vals[CFG_BATT_MIN_MV]   = s.batt_min;
    vals[CFG_BATT_MAX_MV]   = s.batt_max;
    vals[CFG_BAR_FULL]      = s.bar_full;
    vals[CFG_BATT_SHOW_MS]  = s.show_ms;
    vals[CFG_PWM_FULL]      = s.pwm_full;
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[CFG_IDX_W'(i)];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    tmr_cfg = s;
  endtask

  function automatic logic [VAL_W-1:0] random_length();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      default: return VAL_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic timer_settings_t random_settings();
    timer_settings_t s;
    s.work_s  = random_length();
    s.break_s = random_length();
    case ($urandom_range(0, 3))
      0:       s.scale = 8'd1;
      1:       s.scale = 8'hFF;
      default: s.scale = SCALE_W'($urandom_range(1, 255));
    endcase
    s.batt_min = VAL_W'($urandom_range(0, 60000));
    case ($urandom_range(0, 7))
      0:       s.batt_max = s.batt_min;
      1:       s.batt_max = VAL_W'($urandom_range(0, 65535));
      2: begin
        s.batt_min = '0;
        s.batt_max = 16'hFFFF;
      end
      default: s.batt_max = s.batt_min + VAL_W'($urandom_range(1, 5000));
    endcase
    case ($urandom_range(0, 3))
      0:       s.bar_full = 16'd1;
      1:       s.bar_full = 16'hFFFF;
      default: s.bar_full = VAL_W'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 3))
      0:       s.show_ms = '0;
      1:       s.show_ms = 16'hFFFF;
      default: s.show_ms = VAL_W'($urandom_range(0, 3000));
    endcase
    case ($urandom_range(0, 3))
      0:       s.pwm_full = '0;
      1:       s.pwm_full = 16'hFFFF;
      default: s.pwm_full = VAL_W'($urandom_range(0, 65535));
    endcase
    return s;
  endfunction

  // Advance the event clock; now and then jump anywhere in the 32-bit range
  function automatic logic [TIME_W-1:0] next_now();
    if ($urandom_range(0, 15) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + TIME_W'($urandom_range(1, 2000));
    return clock_ms;
  endfunction

  function automatic logic [MV_W-1:0] random_mv();
    if (tmr_cfg.batt_min <= tmr_cfg.batt_max && $urandom_range(0, 9) < 7)
      return MV_W'($urandom_range(tmr_cfg.batt_max, tmr_cfg.batt_min));
    return MV_W'($urandom);
  endfunction

  // Mostly full work/break runs with random content, the rest loose events
  task automatic send_random_traffic(int count);
    int sent;
    int ticks;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        send_event(REQ_LONG, next_now(), random_mv());
        send_event(REQ_SHORT, next_now(), random_mv());
        sent += 2;
        ticks = $urandom_range(1, 24);
        for (int k = 0; k < ticks; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            send_event(REQ_SHORT, next_now(), random_mv());
            sent++;
          end
          send_event(REQ_TICK, next_now(), random_mv());
          sent++;
        end
      end else begin
        send_event(REQ_W'($urandom_range(0, 3)), next_now(), random_mv());
        sent++;
      end
    end
  endtask

  // Reset settings: blinking, run and pause, deadline wrap, charge limits
  task automatic test_default_settings();
    send_event(REQ_TICK, 32'd0, 16'd0);
    send_event(REQ_TICK, 32'd1, 16'd0);
    send_event(REQ_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF);
    send_event(REQ_SHORT, 32'd2, 16'd0);
    send_event(REQ_TICK, 32'd3, 16'd0);
    send_event(REQ_SHORT, 32'd4, 16'd0);
    send_event(REQ_LONG, 32'hFFFF_FC00, 16'd0);
    send_event(REQ_TICK, 32'd1000, 16'd0);
    send_event(REQ_TICK, 32'hFFFF_FFFF, 16'd0);
    send_event(REQ_LONG, 32'd5000, 16'hFFFF);
    send_event(REQ_LONG, 32'd5001, RST_BATT_MAX_MV);
  endtask

  // Counter already at zero and zero-length reloads
  task automatic test_counter_edges();
    timer_settings_t s;
    s = DEFAULT_SETTINGS;
    s.work_s  = 16'd1;
    s.break_s = 16'd0;
    settle();
    load_settings(s);
    send_event(REQ_LONG, 32'd10, 16'd3600);
    send_event(REQ_SHORT, 32'd11, 16'd0);
    send_event(REQ_TICK, 32'd12, 16'd0);
    send_event(REQ_TICK, 32'd13, 16'd0);
    s.work_s = 16'd0;
    settle();
    load_settings(s);
    send_event(REQ_LONG, 32'd20, 16'd3600);
    send_event(REQ_SHORT, 32'd21, 16'd0);
    send_event(REQ_TICK, 32'd22, 16'd0);
  endtask

  // Break progress beyond 16 bits saturates
  task automatic test_break_saturation();
    timer_settings_t s;
    s = DEFAULT_SETTINGS;
    s.work_s   = 16'd1;
    s.break_s  = 16'hFFFF;
    s.scale    = 8'hFF;
    s.pwm_full = 16'hFFFF;
    s.bar_full = 16'hFFFF;
    s.show_ms  = '0;
    settle();
    load_settings(s);
    send_event(REQ_LONG, 32'd0, RST_BATT_MAX_MV);
    send_event(REQ_SHORT, 32'd1, 16'd0);
    send_event(REQ_TICK, 32'd2, 16'd0);
    send_event(REQ_TICK, 32'd3, 16'd0);
  endtask

  // Equal battery limits and inverted limits
  task automatic test_battery_window();
    timer_settings_t s;
    s = DEFAULT_SETTINGS;
    s.batt_min = 16'd2000;
    s.batt_max = 16'd2000;
    settle();
    load_settings(s);
    send_event(REQ_LONG, 32'd100, 16'd2000);
    s.batt_min = 16'hFFFF;
    s.batt_max = 16'd0;
    settle();
    load_settings(s);
    send_event(REQ_LONG, 32'd200, 16'd100);
    send_event(REQ_LONG, 32'd300, 16'd0);
  endtask

  // Several register settings, the extremes first
  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0:       load_settings(LOW_SETTINGS);
        1:       load_settings(HIGH_SETTINGS);
        default: load_settings(random_settings());
      endcase
      send_random_traffic(65);
    end
  endtask

  // Hold off the receiver while events keep coming so the input stalls
  task automatic test_output_backpressure();
    settle();
    load_settings(random_settings());
    hold_off_request = 1'b1;
    send_random_traffic(30);
  endtask

  // Back-to-back beats with no idling on either side
  task automatic test_steady_stream();
    idling_on = 1'b0;
    send_random_traffic(40);
  endtask

  // Receiver: random ready bursts, plus one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("result beat with nothing pending", 32'd1, 32'd0);
      end else begin
        want = pending_responses.pop_front();
        check_field("bar_write", 32'(out_bar_write), 32'(want.bar_write));
        check_field("bar_value", 32'(out_bar_value), 32'(want.bar_value));
        check_field("leds_write", 32'(out_leds_write), 32'(want.leds_write));
        check_field("red_pwm", 32'(out_red_pwm), 32'(want.red_pwm));
        check_field("green_pwm", 32'(out_green_pwm), 32'(want.green_pwm));
        check_field("beep_pattern", 32'(out_beep_pattern), 32'(want.beep));
        check_field("is_running", 32'(out_is_running), 32'(want.running));
        check_field("in_break", 32'(out_in_break), 32'(want.in_break));
        check_field("seconds_left", 32'(out_seconds_left), 32'(want.seconds_left));
      end
    end
  end

  // Stop a hung run: count cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_settings();
    test_counter_edges();
    test_break_saturation();
    test_battery_window();
    test_random_phases();
    test_output_backpressure();
    test_steady_stream();
    settle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
